// ===== src/ertmn_pkg.sv =====
// Shared constants, types and command/status bundles for the edge-rate to note block.
package ertmn_pkg;

   // Ring of edge intervals and counter sizing
   localparam int SAMPLES     = 4;
   localparam int COUNT_WIDTH = 16;
   localparam int IDX_W       = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int SUM_W       = COUNT_WIDTH + $clog2(SAMPLES);

   // Configuration register sizing
   localparam int CFG_W  = 16;
   localparam int NOTE_W = 7;
   localparam int CMP_W  = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

   // Divider sizing: wide enough for the interval sum and for ten times the span
   localparam int SPAN_SCALE = 10;
   localparam int NUM_W      = 11;
   localparam int DIV_W      = (SUM_W > NUM_W) ? SUM_W : NUM_W;
   localparam int STEP_W     = $clog2(DIV_W);

   // Stream widths
   localparam int REQ_W = 8;
   localparam int RSP_W = 24;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [NOTE_W-1:0]      NOTE_MAX  = 7'd127;

   // Register indexes
   localparam logic [1:0] REG_NOTE_PERIOD  = 2'd0;
   localparam logic [1:0] REG_EDGE_TIMEOUT = 2'd1;
   localparam logic [1:0] REG_LOWEST_NOTE  = 2'd2;
   localparam logic [1:0] REG_NOTE_SPAN    = 2'd3;

   // Register reset values
   localparam logic [CFG_W-1:0]  RST_NOTE_PERIOD  = 16'd172;
   localparam logic [CFG_W-1:0]  RST_EDGE_TIMEOUT = 16'd172;
   localparam logic [NOTE_W-1:0] RST_LOWEST_NOTE  = 7'd32;
   localparam logic [NOTE_W-1:0] RST_NOTE_SPAN    = 7'd64;
   localparam logic [NOTE_W-1:0] RST_SOUNDING     = 7'd32;

   // Controller to datapath commands
   typedef struct packed {
      logic load_item;
      logic div_note;
      logic commit;
      logic load_out;
   } ertmn_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic decide;
      logic mean_ok;
      logic div_busy;
      logic out_free;
   } ertmn_sts_type;

endpackage

// ===== src/ertmn_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ertmn_div
   import ertmn_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic [DIV_W-1:0] quotient,
   output logic             busy
);

   logic             busy_ff, busy_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] den_ff, den_in;
   logic [DIV_W:0]   trial;
   logic             fits;

   // Shift in the next dividend bit and trial-subtract
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_W'(trial - {1'b0, den_ff}) : trial[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         if (cnt_ff == STEP_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quotient = quo_ff;
   assign busy     = busy_ff;

endmodule

// ===== src/ertmn_dp.sv =====
// Datapath: counters, interval ring, note arithmetic, config and result registers.
module ertmn_dp
   import ertmn_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ertmn_cmd_type     cmd,
   output ertmn_sts_type     sts,
   input  logic              edge_seen,
   input  logic              link_up,
   input  logic              csr_we,
   input  logic [1:0]        csr_addr,
   input  logic [CFG_W-1:0]  csr_wdata,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output logic [RSP_W-1:0]  rsp_tdata
);

   logic [CFG_W-1:0]       period_ff, period_in;
   logic [CFG_W-1:0]       timeout_ff, timeout_in;
   logic [NOTE_W-1:0]      lowest_ff, lowest_in;
   logic [NOTE_W-1:0]      span_ff, span_in;

   logic [COUNT_WIDTH-1:0] tse_ff, tse_in;
   logic [COUNT_WIDTH-1:0] played_ff, played_in;
   logic [COUNT_WIDTH-1:0] store_ff [SAMPLES];
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   sounding_ff, sounding_in;
   logic [NOTE_W-1:0]      snote_ff, snote_in;
   logic                   led_ff, led_in;
   logic                   decide_ff, decide_in;

   logic                   off_v_ff, off_v_in;
   logic [NOTE_W-1:0]      off_n_ff, off_n_in;
   logic                   on_v_ff, on_v_in;
   logic [NOTE_W-1:0]      on_n_ff, on_n_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]       rsp_data_ff, rsp_data_in;

   logic [COUNT_WIDTH-1:0] tse_inc, played_inc;
   logic                   store_we;

   logic [SUM_W-1:0]       mean;
   logic                   div_start;
   logic [DIV_W-1:0]       div_dividend, div_divisor, div_quo;
   logic                   div_busy;

   logic [DIV_W:0]         note_sum, note_limit, note_clamp;
   logic [NOTE_W-1:0]      note_val;

   // Saturating tick counters
   assign tse_inc    = (tse_ff == COUNT_MAX) ? tse_ff : tse_ff + 1'b1;
   assign played_inc = (played_ff == COUNT_MAX) ? played_ff : played_ff + 1'b1;

   // Configuration writes; unknown indexes fall through
   always_comb begin
      period_in  = period_ff;
      timeout_in = timeout_ff;
      lowest_in  = lowest_ff;
      span_in    = span_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_NOTE_PERIOD:  period_in  = csr_wdata;
            REG_EDGE_TIMEOUT: timeout_in = csr_wdata;
            REG_LOWEST_NOTE:  lowest_in  = csr_wdata[NOTE_W-1:0];
            REG_NOTE_SPAN:    span_in    = csr_wdata[NOTE_W-1:0];
            default: ;
         endcase
      end
   end

   // Mean of the ring; the sample count is a power of two, so this is a shift
   assign mean = sum_ff / SUM_W'(SAMPLES);

   // Divide ten times the span by the mean
   assign div_start    = cmd.div_note;
   assign div_dividend = DIV_W'(NUM_W'(span_ff) * NUM_W'(SPAN_SCALE));
   assign div_divisor  = DIV_W'(mean);

   ertmn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .busy     (div_busy)
   );

   // Offset the scaled quotient and clamp to the span and the note range
   assign note_sum   = (DIV_W+1)'(div_quo) + (DIV_W+1)'(lowest_ff);
   assign note_limit = (DIV_W+1)'(lowest_ff) + (DIV_W+1)'(span_ff);
   assign note_clamp = (note_sum > note_limit) ? note_limit : note_sum;
   assign note_val   = (note_clamp > (DIV_W+1)'(NOTE_MAX)) ? NOTE_MAX
                                                            : note_clamp[NOTE_W-1:0];

   assign store_we = cmd.load_item & edge_seen;

   // Tick update on a new request, note decision on commit
   always_comb begin
      tse_in      = tse_ff;
      played_in   = played_ff;
      idx_in      = idx_ff;
      sum_in      = sum_ff;
      sounding_in = sounding_ff;
      snote_in    = snote_ff;
      led_in      = led_ff;
      decide_in   = decide_ff;
      off_v_in    = off_v_ff;
      off_n_in    = off_n_ff;
      on_v_in     = on_v_ff;
      on_n_in     = on_n_ff;
      if (cmd.load_item) begin
         played_in = played_inc;
         decide_in = link_up & (CMP_W'(played_inc) > CMP_W'(period_ff));
         off_v_in  = 1'b0;
         off_n_in  = '0;
         on_v_in   = 1'b0;
         on_n_in   = '0;
         if (edge_seen) begin
            sum_in = sum_ff - SUM_W'(store_ff[idx_ff]) + SUM_W'(tse_inc);
            idx_in = (idx_ff == IDX_W'(SAMPLES - 1)) ? '0 : idx_ff + 1'b1;
            tse_in = '0;
            led_in = ~led_ff;
         end else begin
            tse_in = tse_inc;
         end
      end else if (cmd.commit) begin
         if (sounding_ff) begin
            off_v_in    = 1'b1;
            off_n_in    = snote_ff;
            sounding_in = 1'b0;
         end
         if (CMP_W'(tse_ff) < CMP_W'(timeout_ff)) begin
            played_in   = '0;
            on_v_in     = 1'b1;
            on_n_in     = note_val;
            snote_in    = note_val;
            sounding_in = 1'b1;
         end
      end
   end

   // Output register: load a finished result, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {(RSP_W-17)'(0), on_n_ff, on_v_ff, off_n_ff, off_v_ff, led_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= RST_NOTE_PERIOD;
         timeout_ff   <= RST_EDGE_TIMEOUT;
         lowest_ff    <= RST_LOWEST_NOTE;
         span_ff      <= RST_NOTE_SPAN;
         tse_ff       <= '0;
         played_ff    <= '0;
         idx_ff       <= '0;
         sum_ff       <= '0;
         sounding_ff  <= 1'b0;
         snote_ff     <= RST_SOUNDING;
         led_ff       <= 1'b0;
         decide_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SAMPLES; i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         period_ff    <= period_in;
         timeout_ff   <= timeout_in;
         lowest_ff    <= lowest_in;
         span_ff      <= span_in;
         tse_ff       <= tse_in;
         played_ff    <= played_in;
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
         sounding_ff  <= sounding_in;
         snote_ff     <= snote_in;
         led_ff       <= led_in;
         decide_ff    <= decide_in;
         rsp_valid_ff <= rsp_valid_in;
         if (store_we) begin
            store_ff[idx_ff] <= tse_inc;
         end
      end
      off_v_ff    <= off_v_in;
      off_n_ff    <= off_n_in;
      on_v_ff     <= on_v_in;
      on_n_ff     <= on_n_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Status back to the controller; mean of at least two means sum of 2*SAMPLES
   assign sts.decide   = decide_ff;
   assign sts.mean_ok  = (sum_ff >= SUM_W'(2 * SAMPLES));
   assign sts.div_busy = div_busy;
   assign sts.out_free = ~rsp_valid_ff | rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== src/ertmn_ctrl.sv =====
// Controller: sequences one request through update, the note division and result hand-off.
module ertmn_ctrl
   import ertmn_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  ertmn_sts_type sts,
   output ertmn_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_CHECK    = 4'b0010,
      ST_DIV_NOTE = 4'b0100,
      ST_FINISH   = 4'b1000
   } ertmn_state_type;

   ertmn_state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Advance through the request and issue datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.decide && sts.mean_ok) begin
               cmd.div_note = 1'b1;
               state_in     = ST_DIV_NOTE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DIV_NOTE: begin
            if (!sts.div_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/edge_rate_to_midi_note_top.sv =====
// Top level of the edge-rate to MIDI note block.
// Each request passes ST_IDLE, ST_CHECK and ST_FINISH; with a note decision due it also
// waits in ST_DIV_NOTE for the 18-step divider. rsp_tvalid rises once the output is free.
// Only one request is in flight at a time; a new one is taken only back in ST_IDLE.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, active high) restores config defaults and clears counters,
// interval ring, note state and LED.
module edge_rate_to_midi_note_top
   import ertmn_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // [0] edge_seen, [1] link_up, rest zero
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // [0] led_level, [1] note_off_valid,
                                         // [8:2] off_note, [9] note_on_valid,
                                         // [16:10] on_note, rest zero
   input  logic             csr_we,
   input  logic [1:0]       csr_addr,
   input  logic [CFG_W-1:0] csr_wdata
);

   ertmn_cmd_type cmd;
   ertmn_sts_type sts;

   ertmn_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ertmn_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .edge_seen  (req_tdata[0]),
      .link_up    (req_tdata[1]),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== verif/tb_edge_rate_to_midi_note_top.sv =====
// Self-checking testbench for the edge-rate to MIDI note block: directed table, then random ticks.
`timescale 1ns / 100ps

module tb_edge_rate_to_midi_note_top;
   import ertmn_pkg::*;

   localparam int SETTLE_CYCLES = 48;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_TICKS   = 100;
   localparam int HOLD_CYCLES   = 300;

   // One result of a tick, packed as it sits in rsp_tdata[16:0]
   typedef struct packed {
      logic [NOTE_W-1:0] on_note;
      logic              on_valid;
      logic [NOTE_W-1:0] off_note;
      logic              off_valid;
      logic              led;
   } note_result_type;

   typedef enum logic {ROW_TICK, ROW_SETTINGS} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic              sensor_edge;
      logic              link;
      logic              typed;
      note_result_type   want;
      logic [CFG_W-1:0]  period;
      logic [CFG_W-1:0]  timeout;
      logic [NOTE_W-1:0] lowest;
      logic [NOTE_W-1:0] span;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 26;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_we;
   logic [1:0]       csr_addr;
   logic [CFG_W-1:0] csr_wdata;

   // Predictor copy of the settings and the tick state
   logic [CFG_W-1:0]       cfg_period;
   logic [CFG_W-1:0]       cfg_timeout;
   logic [NOTE_W-1:0]      cfg_lowest;
   logic [NOTE_W-1:0]      cfg_span;
   logic [COUNT_WIDTH-1:0] pred_since_edge;
   logic [COUNT_WIDTH-1:0] pred_since_played;
   logic [COUNT_WIDTH-1:0] pred_intervals [SAMPLES];
   logic [IDX_W-1:0]       pred_wr_idx;
   logic                   pred_sounding;
   logic [NOTE_W-1:0]      pred_sounding_note;
   logic                   pred_led;

   note_result_type  pending_notes[$];
   directed_row_type directed_rows [DIRECTED_ROWS];
   int               mismatch_count;
   bit               quiet;
   bit               rsp_hold_pending;

   edge_rate_to_midi_note_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // Advance the predictor by one tick and return the notes it sends
   function automatic note_result_type predict_tick(input logic sensor_edge, input logic link);
      note_result_type   res;
      logic [SUM_W-1:0]  sum;
      int unsigned       mean;
      int unsigned       note;
      int unsigned       ceiling;
      res = '0;
      if (pred_since_edge != COUNT_MAX) pred_since_edge = pred_since_edge + 1'b1;
      if (pred_since_played != COUNT_MAX) pred_since_played = pred_since_played + 1'b1;
      if (sensor_edge) begin
         pred_intervals[pred_wr_idx] = pred_since_edge;
         pred_wr_idx = (pred_wr_idx == IDX_W'(SAMPLES - 1)) ? '0 : pred_wr_idx + 1'b1;
         pred_since_edge = '0;
         pred_led = ~pred_led;
      end
      if (link && pred_since_played > cfg_period) begin
         sum = '0;
         for (int i = 0; i < SAMPLES; i++) sum = sum + pred_intervals[i];
         mean = sum / SAMPLES;
         // mean below two makes no decision at all
         if (mean >= 2) begin
            note = (SPAN_SCALE * cfg_span) / mean + cfg_lowest;
            ceiling = cfg_lowest + cfg_span;
            if (note > ceiling) note = ceiling;
            if (note > NOTE_MAX) note = NOTE_MAX;
            if (pred_sounding) begin
               res.off_valid = 1'b1;
               res.off_note = pred_sounding_note;
               pred_sounding = 1'b0;
            end
            if (pred_since_edge < cfg_timeout) begin
               pred_since_played = '0;
               res.on_valid = 1'b1;
               res.on_note = NOTE_W'(note);
               pred_sounding_note = NOTE_W'(note);
               pred_sounding = 1'b1;
            end
         end
      end
      res.led = pred_led;
      return res;
   endfunction

   function automatic directed_row_type tick_row(input logic sensor_edge, input logic link);
      directed_row_type row;
      row = '0;
      row.kind = ROW_TICK;
      row.sensor_edge = sensor_edge;
      row.link = link;
      return row;
   endfunction

   function automatic directed_row_type typed_row(input logic sensor_edge, input logic link,
                                                  input logic led);
      directed_row_type row;
      row = tick_row(sensor_edge, link);
      row.typed = 1'b1;
      row.want.led = led;
      return row;
   endfunction

   function automatic directed_row_type settings_row(input logic [CFG_W-1:0] period,
                                                     input logic [CFG_W-1:0] timeout,
                                                     input logic [NOTE_W-1:0] lowest,
                                                     input logic [NOTE_W-1:0] span);
      directed_row_type row;
      row = '0;
      row.kind = ROW_SETTINGS;
      row.period = period;
      row.timeout = timeout;
      row.lowest = lowest;
      row.span = span;
      return row;
   endfunction

   // Offer one request, wait for it to be taken, then queue its expected notes
   task automatic send_tick(input logic sensor_edge, input logic link,
                            input logic typed, input note_result_type want);
      note_result_type predicted;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W-2){1'b0}}, link, sensor_edge};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_tick(sensor_edge, link);
      pending_notes.push_back(typed ? want : predicted);
   endtask

   // Drop valid and hold until every expected result has come back
   task automatic drain_notes();
      req_tvalid <= 1'b0;
      while (pending_notes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all four registers back to back; block must be idle
   task automatic write_settings(input logic [CFG_W-1:0] period,
                                 input logic [CFG_W-1:0] timeout,
                                 input logic [NOTE_W-1:0] lowest,
                                 input logic [NOTE_W-1:0] span);
      csr_we    <= 1'b1;
      csr_addr  <= REG_NOTE_PERIOD;
      csr_wdata <= period;
      @(posedge clock);
      csr_addr  <= REG_EDGE_TIMEOUT;
      csr_wdata <= timeout;
      @(posedge clock);
      csr_addr  <= REG_LOWEST_NOTE;
      csr_wdata <= CFG_W'(lowest);
      @(posedge clock);
      csr_addr  <= REG_NOTE_SPAN;
      csr_wdata <= CFG_W'(span);
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_period  = period;
      cfg_timeout = timeout;
      cfg_lowest  = lowest;
      cfg_span    = span;
   endtask

   task automatic report_mismatch(input string field, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, field, want, got);
   endtask

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      note_result_type got;
      note_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[16:0];
         if (pending_notes.size() == 0) begin
            report_mismatch("unexpected result", 0, int'(got));
         end else begin
            want = pending_notes.pop_front();
            if (got.led != want.led) report_mismatch("led_level", want.led, got.led);
            if (got.off_valid != want.off_valid)
               report_mismatch("note_off_valid", want.off_valid, got.off_valid);
            if (got.off_note != want.off_note)
               report_mismatch("off_note", want.off_note, got.off_note);
            if (got.on_valid != want.on_valid)
               report_mismatch("note_on_valid", want.on_valid, got.on_valid);
            if (got.on_note != want.on_note)
               report_mismatch("on_note", want.on_note, got.on_note);
         end
      end
   end

   // Result side: random stalls, one long hold-off on request, none when quiet
   initial begin
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (rsp_hold_pending) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold_pending = 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Hard stop in case the block hangs
   initial begin
      #60_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      logic        sensor_edge;
      logic        link;
      int unsigned gap_max;
      int unsigned countdown;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = REG_NOTE_PERIOD;
      csr_wdata = '0;
      mismatch_count = 0;
      quiet = 1'b0;
      rsp_hold_pending = 1'b0;
      cfg_period = RST_NOTE_PERIOD;
      cfg_timeout = RST_EDGE_TIMEOUT;
      cfg_lowest = RST_LOWEST_NOTE;
      cfg_span = RST_NOTE_SPAN;
      pred_since_edge = '0;
      pred_since_played = '0;
      for (int i = 0; i < SAMPLES; i++) pred_intervals[i] = '0;
      pred_wr_idx = '0;
      pred_sounding = 1'b0;
      pred_sounding_note = RST_SOUNDING;
      pred_led = 1'b0;

      directed_rows = '{
         // after reset: nothing sounds, LED follows the edges
         typed_row(1'b0, 1'b0, 1'b0),
         typed_row(1'b1, 1'b1, 1'b1),
         typed_row(1'b1, 1'b0, 1'b0),
         // shortest period, longest timeout, widest span: clamps to the range top
         settings_row(16'd1, 16'hFFFF, 7'd0, 7'd127),
         tick_row(1'b0, 1'b1),   // mean below two, no decision
         tick_row(1'b0, 1'b1),
         tick_row(1'b1, 1'b1),
         tick_row(1'b0, 1'b1),
         tick_row(1'b0, 1'b1),
         tick_row(1'b1, 1'b1),   // first note starts with nothing sounding
         tick_row(1'b0, 1'b1),
         tick_row(1'b0, 1'b1),   // release and restart
         tick_row(1'b1, 1'b0),   // link down: no decision
         // shortest timeout, highest lowest note: note clamps to 127
         settings_row(16'd1, 16'd1, 7'd127, 7'd127),
         tick_row(1'b0, 1'b1),   // off only, edge too old
         tick_row(1'b1, 1'b1),
         tick_row(1'b0, 1'b1),
         // period beyond any count: never decides
         settings_row(16'hFFFF, 16'hFFFF, 7'd0, 7'd0),
         tick_row(1'b1, 1'b1),
         tick_row(1'b0, 1'b1),
         // zero span, zero lowest note
         settings_row(16'd2, 16'd100, 7'd0, 7'd0),
         tick_row(1'b1, 1'b1),
         tick_row(1'b0, 1'b1),
         tick_row(1'b0, 1'b1),
         tick_row(1'b1, 1'b1),
         tick_row(1'b0, 1'b1)
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_SETTINGS) begin
            drain_notes();
            write_settings(directed_rows[r].period, directed_rows[r].timeout,
                           directed_rows[r].lowest, directed_rows[r].span);
         end else begin
            send_tick(directed_rows[r].sensor_edge, directed_rows[r].link,
                      directed_rows[r].typed, directed_rows[r].want);
         end
      end
      drain_notes();

      // Random phases: steady edge trains with random content, some noise
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         unique case (p)
            0: write_settings(16'd1, 16'd1, 7'd0, 7'd0);
            1: write_settings(16'hFFFF, 16'hFFFF, 7'd127, 7'd127);
            2: write_settings(16'd1, 16'hFFFF, 7'd0, 7'd127);
            3: write_settings(16'd2, 16'd2, 7'd127, 7'd0);
            default: write_settings(CFG_W'($urandom_range(1, 40)),
                                    CFG_W'($urandom_range(0, 3) == 0 ? $urandom_range(1, 65535)
                                                                     : $urandom_range(1, 64)),
                                    NOTE_W'($urandom_range(0, 127)),
                                    NOTE_W'($urandom_range(0, 127)));
         endcase
         // last phase runs without idling
         quiet = (p == RANDOM_PHASES - 1);
         // stall the result side for a long stretch while requests keep coming
         if (p == 2) rsp_hold_pending = 1'b1;
         gap_max = $urandom_range(2, 24);
         countdown = $urandom_range(0, gap_max);
         for (int i = 0; i < PHASE_TICKS; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               sensor_edge = 1'($urandom_range(0, 1));
               link = 1'($urandom_range(0, 1));
            end else begin
               link = ($urandom_range(0, 15) != 0);
               if (countdown == 0) begin
                  sensor_edge = 1'b1;
                  countdown = $urandom_range(1, gap_max);
               end else begin
                  sensor_edge = 1'b0;
                  countdown--;
               end
            end
            send_tick(sensor_edge, link, 1'b0, '0);
            // pause the sender once mid-phase until everything is back
            if (p == 5 && i == PHASE_TICKS / 2) drain_notes();
         end
         drain_notes();
      end

      while (pending_notes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_notes.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
